// File: hw/rtl/saftl_pkg.sv
`timescale 1ns / 1ps

package saftl_pkg;

  // Fixed widths of the result fields.
  localparam int unsigned TAG_OUT_W = 24;
  localparam int unsigned SET_OUT_W = 6;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  // Outcome of one lookup against a set row.
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

endpackage

// File: hw/rtl/set_assoc_fifo_tag_lookup.sv
`timescale 1ns / 1ps

// Tag store of a set-associative cache with FIFO replacement. Each input
// transfer carries one load address; the low OFFSET_BITS bits are dropped,
// the next clog2(SETS) bits pick the set (wrapping modulo SETS), and the
// rest form the tag. The result reports a hit, or on a miss fills the
// lowest free way, or evicts the oldest way of a full set and returns its
// tag (low 24 bits). Hits do not refresh FIFO order. Each set lives in one
// row of a single-port-write, registered-read memory: ways' tags, a fill
// count and the oldest-way pointer. An item takes two steps: accept
// reads the set row, then the lookup state compares all ways in parallel
// and writes the row back; the next address is taken in the cycle after
// write-back, so back-to-back items to the same set always see the
// updated row. A full result register holds the lookup cycle until the
// result transfer drains it. After reset the block sweeps all SETS rows
// to clear them, one row per cycle, and takes no input during the sweep.
module set_assoc_fifo_tag_lookup #(
  parameter int unsigned WAYS        = 2,
  parameter int unsigned SETS        = 64,
  parameter int unsigned OFFSET_BITS = 2,
  parameter int unsigned ADDR_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ADDR_WIDTH-1:0]               address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic                                evicted,
  output logic [saftl_pkg::TAG_OUT_W-1:0]     evicted_tag,
  output logic [saftl_pkg::SET_OUT_W-1:0]     set_index
);

  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned SHIFT    = OFFSET_BITS + SET_BITS;
  localparam int unsigned TAG_W    = (ADDR_WIDTH > SHIFT) ? ADDR_WIDTH - SHIFT : 1;
  localparam int unsigned WAY_IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W    = $clog2(WAYS + 1);
  localparam int unsigned ROW_W    = WAYS * TAG_W + CNT_W + WAY_IW;

  saftl_pkg::state_t state, state_next;

  logic [SET_IW-1:0] clr_idx;
  logic [SET_IW-1:0] set_field;
  logic [SET_IW-1:0] set_in;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_IW-1:0] set_q;
  logic [TAG_W-1:0]  tag_q;
  logic              accept;
  logic              commit;

  // Set row memory.
  logic [ROW_W-1:0]  mem [SETS];
  logic [ROW_W-1:0]  rd_row;
  logic              mem_we;
  logic [SET_IW-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;

  logic [WAYS-1:0][TAG_W-1:0] rd_tags;
  logic [CNT_W-1:0]           rd_count;
  logic [WAY_IW-1:0]          rd_oldest;
  logic [WAYS-1:0][TAG_W-1:0] new_tags;
  logic [CNT_W-1:0]           new_count;
  logic [WAY_IW-1:0]          new_oldest;
  logic [TAG_W-1:0]           victim_tag;
  saftl_pkg::lookup_t         result;

  // Split the address into set and tag.
  assign set_field = SET_IW'(address >> OFFSET_BITS);
  assign tag_in    = TAG_W'(address >> SHIFT);

  always_comb begin
    if (SET_BITS == 0) begin
      set_in = '0;
    end else if ({1'b0, set_field} >= (SET_IW + 1)'(SETS)) begin
      // Index field past the last set: wrap once.
      set_in = SET_IW'({1'b0, set_field} - (SET_IW + 1)'(SETS));
    end else begin
      set_in = set_field;
    end
  end

  // Handshakes: take an address only when idle; finish the lookup only
  // when the result register is free or draining this cycle.
  assign in_ready = (state == saftl_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == saftl_pkg::ST_LOOKUP) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      saftl_pkg::ST_CLEAR: begin
        if (clr_idx == SET_IW'(SETS - 1)) begin
          state_next = saftl_pkg::ST_IDLE;
        end
      end
      saftl_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = saftl_pkg::ST_LOOKUP;
        end
      end
      saftl_pkg::ST_LOOKUP: begin
        if (commit) begin
          state_next = saftl_pkg::ST_IDLE;
        end
      end
      default: state_next = saftl_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= saftl_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == saftl_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Hold the split address for the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Write the clearing sweep or the updated row; read on accept.
  assign mem_we    = (state == saftl_pkg::ST_CLEAR) || commit;
  assign mem_waddr = (state == saftl_pkg::ST_CLEAR) ? clr_idx : set_q;
  assign mem_wdata = (state == saftl_pkg::ST_CLEAR) ? '0 : {new_tags, new_count, new_oldest};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_row <= mem[set_in];
    end
  end

  assign rd_tags   = rd_row[ROW_W-1 -: WAYS * TAG_W];
  assign rd_count  = rd_row[WAY_IW +: CNT_W];
  assign rd_oldest = rd_row[WAY_IW-1:0];

  saftl_way_match #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .CNT_W  (CNT_W),
    .WAY_IW (WAY_IW)
  ) u_match (
    .row_tags   (rd_tags),
    .row_count  (rd_count),
    .row_oldest (rd_oldest),
    .tag        (tag_q),
    .result     (result),
    .new_tags   (new_tags),
    .new_count  (new_count),
    .new_oldest (new_oldest),
    .victim_tag (victim_tag)
  );

  // Result register: load on commit, drop valid once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit         <= result.hit;
      evicted     <= result.evict;
      evicted_tag <= result.evict ? saftl_pkg::TAG_OUT_W'(victim_tag) : '0;
      set_index   <= saftl_pkg::SET_OUT_W'(set_q);
    end
  end

endmodule

// File: hw/rtl/saftl_way_match.sv
`timescale 1ns / 1ps

// Compare a tag against the filled ways of one set row and build the
// updated row. Ways fill from way 0 upward and never empty, so the fill
// count alone says which ways are valid.
module saftl_way_match #(
  parameter int unsigned WAYS   = 2,
  parameter int unsigned TAG_W  = 24,
  parameter int unsigned CNT_W  = 2,
  parameter int unsigned WAY_IW = 1
) (
  input  logic [WAYS-1:0][TAG_W-1:0] row_tags,
  input  logic [CNT_W-1:0]           row_count,
  input  logic [WAY_IW-1:0]          row_oldest,
  input  logic [TAG_W-1:0]           tag,
  output saftl_pkg::lookup_t         result,
  output logic [WAYS-1:0][TAG_W-1:0] new_tags,
  output logic [CNT_W-1:0]           new_count,
  output logic [WAY_IW-1:0]          new_oldest,
  output logic [TAG_W-1:0]           victim_tag
);

  logic              hit;
  logic              full;
  logic [WAY_IW-1:0] victim;
  logic [WAY_IW-1:0] oldest_adv;

  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < int'(WAYS); w++) begin
      if ((CNT_W'(w) < row_count) && (row_tags[w] == tag)) begin
        hit = 1'b1;
      end
    end
  end

  assign full       = (row_count == CNT_W'(WAYS));
  // Fill the lowest free way; once full, replace the oldest.
  assign victim     = full ? row_oldest : WAY_IW'(row_count);
  assign oldest_adv = (row_oldest == WAY_IW'(WAYS - 1)) ? '0 : row_oldest + 1'b1;
  assign victim_tag = row_tags[victim];

  always_comb begin
    new_tags = row_tags;
    if (!hit) begin
      new_tags[victim] = tag;
    end
  end

  assign new_count    = (!hit && !full) ? row_count + 1'b1 : row_count;
  assign new_oldest   = (!hit && full) ? oldest_adv : row_oldest;
  assign result.hit   = hit;
  assign result.evict = !hit && full;

endmodule

// File: tb/sv/tag_lookup_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tag lookup, predicts each result from the
// accepted addresses and compares result transfers in order.
module tag_lookup_checker #(
  parameter int unsigned WAYS        = 2,
  parameter int unsigned SETS        = 64,
  parameter int unsigned OFFSET_BITS = 2,
  parameter int unsigned ADDR_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [ADDR_WIDTH-1:0]               address,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                hit,
  input  logic                                evicted,
  input  logic [saftl_pkg::TAG_OUT_W-1:0]     evicted_tag,
  input  logic [saftl_pkg::SET_OUT_W-1:0]     set_index,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  lookups,
  output int                                  hits,
  output int                                  evictions
);

  localparam int unsigned SET_BITS = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int unsigned TAG_W    = ADDR_WIDTH - OFFSET_BITS - SET_BITS;

  typedef struct packed {
    logic                              hit;
    logic                              evicted;
    logic [saftl_pkg::TAG_OUT_W-1:0]   evicted_tag;
    logic [saftl_pkg::SET_OUT_W-1:0]   set_index;
  } lookup_result_t;

  logic [TAG_W-1:0] tag_mem  [SETS][WAYS];
  logic             line_ok  [SETS][WAYS];
  int               fifo_head[SETS];
  lookup_result_t   expected_lookups[$];

  // Look up one address in the model tag store and update it.
  function automatic lookup_result_t predict_lookup(input logic [ADDR_WIDTH-1:0] a);
    lookup_result_t r;
    logic [TAG_W-1:0] t;
    int s;
    int w;
    int free_w;
    int v;
    r = '0;
    s = int'((a >> OFFSET_BITS) & ((64'd1 << SET_BITS) - 1)) % SETS;
    t = TAG_W'(a >> (OFFSET_BITS + SET_BITS));
    r.set_index = s[saftl_pkg::SET_OUT_W-1:0];
    free_w = WAYS;
    for (w = 0; w < WAYS; w++) begin
      if (line_ok[s][w]) begin
        if (tag_mem[s][w] == t) r.hit = 1'b1;
      end else if (free_w == WAYS) begin
        free_w = w;
      end
    end
    if (!r.hit) begin
      if (free_w < WAYS) begin
        tag_mem[s][free_w] = t;
        line_ok[s][free_w] = 1'b1;
      end else begin
        v = fifo_head[s];
        r.evicted = 1'b1;
        r.evicted_tag = saftl_pkg::TAG_OUT_W'(tag_mem[s][v]);
        tag_mem[s][v] = t;
        fifo_head[s] = (v + 1) % WAYS;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        fifo_head[s] = 0;
        for (int w = 0; w < WAYS; w++) begin
          line_ok[s][w] = 1'b0;
          tag_mem[s][w] = '0;
        end
      end
      expected_lookups.delete();
      fail_count = 0;
      lookups = 0;
      hits = 0;
      evictions = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t ns: result transfer with no lookup waiting (set %0d)",
                   $time, set_index);
          fail_count++;
        end else begin
          exp_r = expected_lookups[0];
          expected_lookups.delete(0);
          check_field("hit", 32'(exp_r.hit), 32'(hit));
          check_field("evicted", 32'(exp_r.evicted), 32'(evicted));
          check_field("evicted_tag", 32'(exp_r.evicted_tag), 32'(evicted_tag));
          check_field("set_index", 32'(exp_r.set_index), 32'(set_index));
          lookups++;
          if (exp_r.hit) hits++;
          if (exp_r.evicted) evictions++;
        end
      end
      if (in_valid && in_ready) begin
        expected_lookups.insert(expected_lookups.size(), predict_lookup(address));
      end
      pending <= expected_lookups.size();
    end
  end

endmodule

// File: tb/sv/set_assoc_fifo_tag_lookup_test.sv
`timescale 1ns / 1ps

// Top of the tag lookup bench: makes address traffic and result back-pressure,
// and gives the verdict. Prediction and comparison live in the checker.
module set_assoc_fifo_tag_lookup_test;

  localparam int unsigned ADDR_WIDTH  = 32;
  localparam int unsigned OFFSET_BITS = 2;
  localparam int unsigned RANDOM_ITEMS = 800;
  // Cycles without any transfer before the run is declared hung. The slowest
  // correct stretch is the post-reset clear sweep or a long sender gap
  // stacked on a long receiver stall plus the lookup.
  localparam int unsigned HANG_LIMIT = 2000;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [ADDR_WIDTH-1:0]             address = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              hit;
  logic                              evicted;
  logic [saftl_pkg::TAG_OUT_W-1:0]   evicted_tag;
  logic [saftl_pkg::SET_OUT_W-1:0]   set_index;

  int fail_count;
  int pending;
  int lookups;
  int hits;
  int evictions;

  // Set by the stimulus for stretches where neither side idles.
  bit no_idle = 1'b0;
  int stall_left;
  int quiet_cycles;
  int directed_sent;
  int random_sent;

  set_assoc_fifo_tag_lookup DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .address    (address),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_tag(evicted_tag),
    .set_index  (set_index)
  );

  tag_lookup_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .address    (address),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_tag(evicted_tag),
    .set_index  (set_index),
    .fail_count (fail_count),
    .pending    (pending),
    .lookups    (lookups),
    .hits       (hits),
    .evictions  (evictions)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Build an address from tag, set and byte offset.
  function automatic logic [ADDR_WIDTH-1:0] make_addr(input logic [23:0] tag,
                                                      input logic [5:0] set_no,
                                                      input logic [1:0] offset);
    return {tag, set_no, offset};
  endfunction

  // Offer one address and hold it until the input transfer happens. Valid is
  // only dropped when a gap comes first, so a back-to-back item keeps valid
  // high with a single assignment per edge.
  task automatic send_addr(input logic [ADDR_WIDTH-1:0] a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    address  <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result side back-pressure: random stalls, none while no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hang detection: count cycles where neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d lookups outstanding",
               $time, HANG_LIMIT, pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [23:0] tag_pool[5];
    logic [5:0]  set_pool[3];
    int          n_tags;
    int          n_sets;
    int          seg_len;
    int          seg_kind;
    logic [ADDR_WIDTH-1:0] a;

    directed_sent = 0;
    random_sent   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed corners. Set 0 walks through fill, hit, and FIFO eviction
    // with the pointer wrapping; set 63 takes the all-ones address.
    send_addr('0);                                   // cold miss, fill way 0
    send_addr(make_addr(24'h0, 6'd0, 2'd3));         // same line, other offset: hit
    send_addr('1);                                   // top set, top tag
    send_addr(make_addr(24'hFFFFFF, 6'd63, 2'd0));   // hit
    send_addr(make_addr(24'h1, 6'd0, 2'd1));         // fill way 1, set now full
    send_addr(make_addr(24'h0, 6'd0, 2'd2));         // hit, must not refresh order
    send_addr(make_addr(24'h2, 6'd0, 2'd0));         // evict tag 0 (oldest)
    send_addr(make_addr(24'h0, 6'd0, 2'd0));         // evict tag 1, pointer wraps
    send_addr(make_addr(24'h2, 6'd0, 2'd0));         // hit
    send_addr(make_addr(24'hFFFFFF, 6'd0, 2'd3));    // evict tag 2
    send_addr(make_addr(24'h0, 6'd63, 2'd2));        // fill second way of top set
    send_addr(make_addr(24'h5, 6'd63, 2'd1));        // evict all-ones tag
    send_addr(make_addr(24'h0, 6'd63, 2'd0));        // hit
    send_addr(32'hAAAA_AAAA);
    send_addr(32'h5555_5555);
    send_addr(32'hAAAA_AAAA);                        // hit on alternating pattern
    send_addr(make_addr(24'h800000, 6'd32, 2'd0));   // tag MSB alone
    directed_sent = 17;

    // Random segments. Most reuse a few sets and a small tag pool, so hits
    // and FIFO evictions come often; the rest are unrelated addresses.
    while (random_sent < RANDOM_ITEMS) begin
      no_idle  = ($urandom_range(0, 4) == 0);
      seg_len  = $urandom_range(10, 60);
      seg_kind = $urandom_range(0, 9);
      n_tags   = $urandom_range(2, 5);
      n_sets   = $urandom_range(1, 3);
      for (int i = 0; i < n_tags; i++) begin
        case ($urandom_range(0, 9))
          0: tag_pool[i] = '0;
          1: tag_pool[i] = '1;
          default: tag_pool[i] = 24'($urandom);
        endcase
      end
      for (int i = 0; i < n_sets; i++) set_pool[i] = 6'($urandom);
      for (int k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++) begin
        if (seg_kind < 8 && $urandom_range(0, 9) != 0) begin
          a = make_addr(tag_pool[$urandom_range(0, n_tags - 1)],
                        set_pool[$urandom_range(0, n_sets - 1)],
                        2'($urandom));
        end else begin
          a = ADDR_WIDTH'($urandom);
        end
        send_addr(a);
        random_sent++;
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Let the checker see the last push, then drain and watch for strays.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d lookups: %0d hits, %0d FIFO evictions",
             lookups, hits, evictions);
    $display("Traffic: %0d corner addresses, %0d random addresses under back-pressure",
             directed_sent, random_sent);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
